>>> hw/rtl/sez_pkg.sv
// Shared types and constants for the screen exclusion zone alpha block.
// No dependencies; used by sez_cell and the top level.
package sez_pkg;

  localparam int unsigned SW = 36;  // signed working width for Q16.16 bounds

  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  localparam logic [0:0] OP_QUERY = 1'b0;
  localparam logic [0:0] OP_WRITE = 1'b1;

  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_COUNT  = 3'd1;
  localparam logic [2:0] CFG_FADE   = 3'd2;
  localparam logic [2:0] CFG_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_HEIGHT = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic        [2:0]  zone_index;
    logic        [15:0] zone_left;
    logic        [15:0] zone_top;
    logic        [15:0] zone_extent_x;
    logic        [15:0] zone_extent_y;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic        [13:0] half_width;
    logic        [13:0] half_height;
  } in_t;

  typedef struct packed {
    logic [16:0] alpha;
    logic        inside_zone;
  } out_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] ext_x;
    logic [15:0] ext_y;
  } zone_t;

  // Query token handed from cell to cell.
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic                 found;
    logic        [15:0]   best_d;
    logic signed [SW-1:0] u;
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] pad_x;
    logic signed [SW-1:0] pad_y;
  } tok_t;

endpackage

>>> hw/rtl/screen_exclusion_zone_alpha_core.sv
// Top level: config registers, query sequencer, shared divider and zone cell chain.
// Depends on sez_pkg, sez_div and sez_cell.
//
//  channel | signals                          | direction
//  in      | in_valid_i/in_ready_o/in_data_i  | item in (query or zone write)
//  out     | out_valid_o/out_ready_i/out_data_o | result item out
//  cfg     | cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i | register write
//
// A zone write, or a bypassed query (disabled, no zones or zero screen size), goes via the
// result register to the output register. Other queries run four divisions, the cell chain
// and, on a fade fringe, a fifth: the single 1-bit-per-cycle divider forms u, v, both pads
// and alpha. Reset clears control state, enable, count and fade, sets a 1920x1080 screen
// and leaves the zone table undefined until written. A stalled output blocks the input.
module screen_exclusion_zone_alpha_core #(
  parameter int MAX_ZONES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sez_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sez_pkg::out_t   out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);

  localparam int unsigned W = sez_pkg::SW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHAIN = 3'd2;
  localparam logic [2:0] S_FDIV  = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  logic        en_q;
  logic [3:0]  count_q;
  logic [15:0] fade_q;
  logic [13:0] scr_w_q, scr_h_q;

  logic [2:0]  state_q, state_d;
  logic [1:0]  sel_q, sel_d;
  logic        go_q, go_d, launch_q, launch_d;
  sez_pkg::in_t  in_q;
  sez_pkg::out_t res_q, res_d, out_q;
  logic          out_valid_q, out_valid_d;
  logic signed [W-1:0] u_q, v_q, px_q, py_q, val_s, q36;
  logic signed [W-1:0] u_d, v_d, px_d, py_d;
  logic [15:0] bd_q, bd_d;

  logic [31:0] dividend;
  logic [15:0] divisor;
  logic        div_done, rem_nz, neg;
  logic [31:0] quo;
  logic [16:0] pxe, pye;
  logic [15:0] pxm, pym;
  logic        bypass;

  sez_pkg::tok_t tok [MAX_ZONES+1];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      count_q <= '0;
      fade_q  <= '0;
      scr_w_q <= 14'd1920;
      scr_h_q <= 14'd1080;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sez_pkg::CFG_ENABLE: en_q    <= cfg_data_i[0];
        sez_pkg::CFG_COUNT:  count_q <= cfg_data_i[3:0];
        sez_pkg::CFG_FADE:   fade_q  <= cfg_data_i;
        sez_pkg::CFG_WIDTH:  scr_w_q <= cfg_data_i[13:0];
        sez_pkg::CFG_HEIGHT: scr_h_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // pixel magnitudes, scaled by 2^16 as dividends
  always_comb begin
    pxe = -{in_q.point_x[15], in_q.point_x};
    pye = -{in_q.point_y[15], in_q.point_y};
    pxm = in_q.point_x[15] ? pxe[15:0] : in_q.point_x;
    pym = in_q.point_y[15] ? pye[15:0] : in_q.point_y;
    neg = 1'b0;
    if (state_q == S_FDIV) begin
      dividend = {bd_q, 16'd0};
      divisor  = fade_q;
    end else begin
      case (sel_q)
        2'd0: begin
          dividend = {pxm, 16'd0};
          divisor  = {2'd0, scr_w_q};
          neg      = in_q.point_x[15];
        end
        2'd1: begin
          dividend = {pym, 16'd0};
          divisor  = {2'd0, scr_h_q};
          neg      = in_q.point_y[15];
        end
        2'd2: begin
          dividend = {2'd0, in_q.half_width, 16'd0};
          divisor  = {2'd0, scr_w_q};
        end
        default: begin
          dividend = {2'd0, in_q.half_height, 16'd0};
          divisor  = {2'd0, scr_h_q};
        end
      endcase
    end
    // floor division of a negative numerator rounds the magnitude up
    q36   = $signed({4'd0, quo});
    val_s = neg ? -(q36 + W'(rem_nz)) : q36;
  end

  sez_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go_q),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_nz_o   (rem_nz)
  );

  assign tok[0] = '{valid: launch_q, hit: 1'b0, found: 1'b0, best_d: 16'd0,
                    u: u_q, v: v_q, pad_x: px_q, pad_y: py_q};

  for (genvar g = 0; g < MAX_ZONES; g++) begin : g_cell
    sez_cell #(.IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (in_valid_i && in_ready_o && in_data_i.opcode == sez_pkg::OP_WRITE),
      .wr_idx_i  (in_data_i.zone_index),
      .wr_zone_i ('{left: in_data_i.zone_left, top: in_data_i.zone_top,
                    ext_x: in_data_i.zone_extent_x, ext_y: in_data_i.zone_extent_y}),
      .count_i   (count_q),
      .fade_i    (fade_q),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  assign bypass = !en_q || count_q == '0 || scr_w_q == '0 || scr_h_q == '0;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    go_d        = 1'b0;
    launch_d    = 1'b0;
    res_d       = res_q;
    u_d         = u_q;
    v_d         = v_q;
    px_d        = px_q;
    py_d        = py_q;
    bd_d        = bd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.opcode == sez_pkg::OP_WRITE) begin
            res_d   = '{alpha: 17'd0, inside_zone: 1'b0};
            state_d = S_RES;
          end else if (bypass) begin
            res_d   = '{alpha: sez_pkg::ALPHA_ONE, inside_zone: 1'b0};
            state_d = S_RES;
          end else begin
            sel_d   = 2'd0;
            go_d    = 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          case (sel_q)
            2'd0:    u_d  = val_s;
            2'd1:    v_d  = val_s;
            2'd2:    px_d = val_s;
            default: py_d = val_s;
          endcase
          if (sel_q == 2'd3) begin
            launch_d = 1'b1;
            state_d  = S_CHAIN;
          end else begin
            sel_d = sel_q + 2'd1;
            go_d  = 1'b1;
          end
        end
      end
      S_CHAIN: begin
        if (tok[MAX_ZONES].valid) begin
          if (tok[MAX_ZONES].hit) begin
            res_d   = '{alpha: 17'd0, inside_zone: 1'b1};
            state_d = S_RES;
          end else if (tok[MAX_ZONES].found) begin
            bd_d    = tok[MAX_ZONES].best_d;
            go_d    = 1'b1;
            state_d = S_FDIV;
          end else begin
            res_d   = '{alpha: sez_pkg::ALPHA_ONE, inside_zone: 1'b0};
            state_d = S_RES;
          end
        end
      end
      S_FDIV: begin
        if (div_done) begin
          res_d   = '{alpha: quo[16:0], inside_zone: 1'b0};
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= '0;
      go_q        <= 1'b0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      go_q        <= go_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (state_q == S_RES && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
    res_q <= res_d;
    u_q   <= u_d;
    v_q   <= v_d;
    px_q  <= px_d;
    py_q  <= py_d;
    bd_q  <= bd_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.inside_zone |-> out_data_o.alpha == 17'd0)
    else $error("inside_zone with nonzero alpha");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.alpha <= sez_pkg::ALPHA_ONE)
    else $error("alpha above one");

  a_token_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_ZONES].valid |-> state_q == S_CHAIN)
    else $error("token left chain outside chain state");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV || state_q == S_FDIV)
    else $error("divider finished with no division pending");

endmodule

>>> hw/rtl/sez_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// Uses no package items.
module sez_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic        rem_nz_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] r, diff;
  logic        ge;

  always_comb begin
    r      = {rem_q, quo_q[31]};
    diff   = r - {1'b0, dvs_q};
    ge     = r >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[15:0] : r[15:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = rem_q != '0;

endmodule

>>> hw/rtl/sez_cell.sv
// One zone cell: holds a rectangle, tests the passing query token against it.
// Depends on sez_pkg.
module sez_cell #(
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [2:0]          wr_idx_i,
  input  sez_pkg::zone_t      wr_zone_i,
  input  logic [3:0]          count_i,
  input  logic [15:0]         fade_i,
  input  sez_pkg::tok_t       tok_i,
  output sez_pkg::tok_t       tok_o
);

  localparam int unsigned W = sez_pkg::SW;

  sez_pkg::zone_t zone_q;
  sez_pkg::tok_t  tok_q, tok_d;

  logic signed [W-1:0] l, t, ex, ey, fe, x0, x1, y0, y1;
  logic signed [W-1:0] dx, dy, dm;
  logic                active, in_zone, fringe;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && int'(wr_idx_i) == IDX) begin
      zone_q <= wr_zone_i;
    end
  end

  always_comb begin
    l  = $signed({20'd0, zone_q.left});
    t  = $signed({20'd0, zone_q.top});
    ex = $signed({20'd0, zone_q.ext_x});
    ey = $signed({20'd0, zone_q.ext_y});
    fe = $signed({20'd0, fade_i});
    x0 = l - tok_i.pad_x;
    x1 = l + ex + tok_i.pad_x;
    y0 = t - tok_i.pad_y;
    y1 = t + ey + tok_i.pad_y;
    active = int'(count_i) > IDX;
    in_zone = tok_i.u >= x0 && tok_i.u <= x1 && tok_i.v >= y0 && tok_i.v <= y1;
    fringe = fade_i != '0 && tok_i.u >= x0 - fe && tok_i.u <= x1 + fe &&
             tok_i.v >= y0 - fe && tok_i.v <= y1 + fe;
    dx = (x0 - tok_i.u > tok_i.u - x1) ? x0 - tok_i.u : tok_i.u - x1;
    dy = (y0 - tok_i.v > tok_i.v - y1) ? y0 - tok_i.v : tok_i.v - y1;
    dm = dx > dy ? dx : dy;
    if (dm < 0) begin
      dm = '0;
    end
    tok_d = tok_i;
    if (tok_i.valid && active && !tok_i.hit) begin
      if (in_zone) begin
        tok_d.hit = 1'b1;
      end else if (fringe && (!tok_i.found || dm[15:0] < tok_i.best_d)) begin
        // inside the fringe the distance never exceeds the fade width
        tok_d.found  = 1'b1;
        tok_d.best_d = dm[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
